>>> rtl/pwmdim_pkg.sv
// ----------------------------------------------------------------------------
// pwmdim_pkg
// Shared types, constants and level helper for the two-channel LED dimmer.
// ----------------------------------------------------------------------------
package pwmdim_pkg;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  localparam logic [7:0] PWM_PERIOD = 8'd100;
  localparam logic [7:0] LEVEL_MAX  = 8'd100;
  localparam logic [7:0] DUTY2_OFS  = 8'd5;
  localparam logic [7:0] STEP_DOWN  = 8'd15;
  localparam logic [7:0] STEP_FLOOR = 8'd10;
  localparam logic [7:0] FADE_STEP  = 8'd2;

  // operation codes
  localparam logic [2:0] OP_PWM_TICK  = 3'd0;
  localparam logic [2:0] OP_FADE_TICK = 3'd1;
  localparam logic [2:0] OP_SET_LEVEL = 3'd2;
  localparam logic [2:0] OP_STEP      = 3'd3;
  localparam logic [2:0] OP_ENABLE    = 3'd4;

  typedef struct packed {
    logic [6:0] duty_one;
    logic [6:0] duty_two;
    logic [6:0] level;
  } level_set_t;

  // clamp to 100 and derive both duties
  function automatic level_set_t apply_level(input logic [7:0] lvl);
    level_set_t r;
    logic [6:0] c;
    c = (lvl > LEVEL_MAX) ? LEVEL_MAX[6:0] : lvl[6:0];
    r.level    = c;
    r.duty_one = {1'b0, c[6:1]};
    r.duty_two = (c < DUTY2_OFS[6:0]) ? c : c - DUTY2_OFS[6:0];
    return r;
  endfunction

endpackage

>>> rtl/pwm_led_dimmer_with_fade_unit.sv
// ----------------------------------------------------------------------------
// pwm_led_dimmer_with_fade_unit
// Two-channel PWM LED dimmer with soft fade-in / fade-out.
// ----------------------------------------------------------------------------
// The result word is registered: it is valid in the cycle after its input word is accepted.
// Throughput: one word per cycle while the output side keeps up; state update is a
// single compare/add pass between the input handshake and the output register.
// s_axis_tready stays high while the output register is empty or being read.
// Reset (rst, synchronous): counter 0, lights off, level 100, duties 50/95,
// no fade pending, output register empty.
module pwm_led_dimmer_with_fade_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [2:0] operation, [10:3] level_value, [11] enable_value, [15:12] zero
  input  logic [pwmdim_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] light1_on, [1] light2_on, [8:2] current_level, [9] transitioning,
  // [15:10] zero
  output logic [pwmdim_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import pwmdim_pkg::*;

  logic [7:0] period_counter, period_counter_next;
  logic       light_one, light_one_next;
  logic       light_two, light_two_next;
  logic [6:0] duty_one, duty_one_next;
  logic [6:0] duty_two, duty_two_next;
  logic [6:0] stored_level, stored_level_next;
  logic [7:0] fade_out_value, fade_out_value_next;
  logic [7:0] fade_in_value, fade_in_value_next;
  logic [6:0] restore_level, restore_level_next;
  logic       enable_request, enable_request_next;
  logic       enable_applied, enable_applied_next;

  logic [2:0] operation;
  logic [7:0] level_value;
  logic       enable_value;
  logic       accept;

  level_set_t ls;
  logic [7:0] cnt_dec;
  logic [7:0] fi_inc;
  logic [7:0] fo_base;
  logic [7:0] fo_dec;
  logic [7:0] lvl_in;
  logic       do_apply;

  assign operation    = s_axis_tdata[2:0];
  assign level_value  = s_axis_tdata[10:3];
  assign enable_value = s_axis_tdata[11];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign cnt_dec = period_counter - 8'd1;
  assign fi_inc  = fade_in_value + FADE_STEP;
  assign fo_base = (fade_out_value == 8'd0) ? {1'b0, stored_level} : fade_out_value;
  assign fo_dec  = fo_base - 8'd1;

  // one level write per word at most; fade-out end overrides with full level
  always_comb begin
    lvl_in   = 8'd0;
    do_apply = 1'b0;
    case (operation)
      OP_FADE_TICK: begin
        if (enable_request != enable_applied) begin
          do_apply = 1'b1;
          if (enable_request) begin
            lvl_in = fi_inc;
          end else if (fo_dec == 8'd0) begin
            lvl_in = LEVEL_MAX;
          end else begin
            lvl_in = fo_dec;
          end
        end
      end
      OP_SET_LEVEL: begin
        do_apply = 1'b1;
        lvl_in   = level_value;
      end
      OP_STEP: begin
        do_apply = 1'b1;
        lvl_in   = ({1'b0, stored_level} > STEP_FLOOR) ?
                   {1'b0, stored_level} - STEP_DOWN : LEVEL_MAX;
      end
      OP_ENABLE: begin
        do_apply = enable_value;
        lvl_in   = 8'd0;
      end
      default: begin
        do_apply = 1'b0;
      end
    endcase
  end

  assign ls = apply_level(lvl_in);

  always_comb begin
    period_counter_next = period_counter;
    light_one_next      = light_one;
    light_two_next      = light_two;
    fade_out_value_next = fade_out_value;
    fade_in_value_next  = fade_in_value;
    restore_level_next  = restore_level;
    enable_request_next = enable_request;
    enable_applied_next = enable_applied;
    duty_one_next       = do_apply ? ls.duty_one : duty_one;
    duty_two_next       = do_apply ? ls.duty_two : duty_two;
    stored_level_next   = do_apply ? ls.level    : stored_level;

    case (operation)
      OP_PWM_TICK: begin
        period_counter_next = cnt_dec;
        if (cnt_dec == 8'd0) begin
          period_counter_next = PWM_PERIOD;
          light_one_next      = 1'b0;
          light_two_next      = 1'b0;
        end
        if ({1'b0, duty_one} >= period_counter_next) light_one_next = 1'b1;
        if ({1'b0, duty_two} >= period_counter_next) light_two_next = 1'b1;
      end
      OP_FADE_TICK: begin
        if (enable_request != enable_applied) begin
          if (enable_request) begin
            fade_in_value_next = fi_inc;
            if (fi_inc >= {1'b0, restore_level}) begin
              fade_in_value_next  = 8'd0;
              enable_applied_next = enable_request;
            end
          end else begin
            if (fade_out_value == 8'd0) begin
              restore_level_next = (stored_level < LEVEL_MAX[6:0]) ?
                                   stored_level : LEVEL_MAX[6:0];
            end
            fade_out_value_next = fo_dec;
            if (fo_dec == 8'd0) begin
              light_one_next      = 1'b0;
              light_two_next      = 1'b0;
              enable_applied_next = enable_request;
            end
          end
        end
      end
      OP_ENABLE: begin
        enable_request_next = enable_value;
        if (enable_value) begin
          light_one_next = 1'b0;
          light_two_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_counter <= 8'd0;
      light_one      <= 1'b0;
      light_two      <= 1'b0;
      duty_one       <= 7'd50;
      duty_two       <= 7'd95;
      stored_level   <= LEVEL_MAX[6:0];
      fade_out_value <= 8'd0;
      fade_in_value  <= 8'd0;
      restore_level  <= LEVEL_MAX[6:0];
      enable_request <= 1'b0;
      enable_applied <= 1'b0;
    end else if (accept) begin
      period_counter <= period_counter_next;
      light_one      <= light_one_next;
      light_two      <= light_two_next;
      duty_one       <= duty_one_next;
      duty_two       <= duty_two_next;
      stored_level   <= stored_level_next;
      fade_out_value <= fade_out_value_next;
      fade_in_value  <= fade_in_value_next;
      restore_level  <= restore_level_next;
      enable_request <= enable_request_next;
      enable_applied <= enable_applied_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {6'd0, (enable_request_next != enable_applied_next),
                       stored_level_next, light_two_next, light_one_next};
    end
  end

  // ---- assertions ----
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    stored_level <= LEVEL_MAX[6:0] && restore_level <= LEVEL_MAX[6:0])
    else $error("level out of range");

  a_duty_one: assert property (@(posedge clk) disable iff (rst)
    duty_one == {1'b0, stored_level[6:1]})
    else $error("duty_one not tracking level");

  a_duty_two: assert property (@(posedge clk) disable iff (rst)
    duty_two == ((stored_level < DUTY2_OFS[6:0]) ? stored_level
                                                 : stored_level - DUTY2_OFS[6:0]))
    else $error("duty_two not tracking level");

  a_result_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid)
    else $error("accepted word produced no result");

  a_trans_flag: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tdata[9] == (enable_request != enable_applied))
    else $error("transitioning flag mismatch");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level check of the two-channel LED dimmer. Words of every operation
// go in, a cycle model tracks the counter, duties, level and fade state, and
// each status word that comes out is compared field by field. Both bus sides
// stall at random, and one long output hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
  import pwmdim_pkg::*;

  localparam int NUM_WORDS = 1550;

  // spare codes, decoded as no-ops
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  class dimmer_scoreboard;
    logic [7:0] count;
    logic       lamp_a, lamp_b;
    logic [7:0] duty_a, duty_b;
    logic [7:0] level;
    logic [7:0] ramp_down, ramp_up;
    logic [7:0] target;
    logic       want_on, is_on;
    logic [15:0] status_queue[$];
    int errors;
    int checked;

    function new();
      count     = 8'd0;
      lamp_a    = 1'b0;
      lamp_b    = 1'b0;
      duty_a    = 8'd50;
      duty_b    = 8'd95;
      level     = LEVEL_MAX;
      ramp_down = 8'd0;
      ramp_up   = 8'd0;
      target    = LEVEL_MAX;
      want_on   = 1'b0;
      is_on     = 1'b0;
      errors    = 0;
      checked   = 0;
    endfunction

    function void set_brightness(logic [7:0] lvl);
      logic [7:0] c;
      c = (lvl > LEVEL_MAX) ? LEVEL_MAX : lvl;
      duty_a = c >> 1;
      duty_b = (c < DUTY2_OFS) ? c : c - DUTY2_OFS;
      level = c;
    endfunction

    function void pwm_step();
      count = count - 8'd1;
      if (count == 8'd0) begin
        count  = PWM_PERIOD;
        lamp_a = 1'b0;
        lamp_b = 1'b0;
      end
      if (duty_a >= count) lamp_a = 1'b1;
      if (duty_b >= count) lamp_b = 1'b1;
    endfunction

    function void fade_step();
      if (want_on == is_on) return;
      if (want_on) begin
        ramp_up = ramp_up + FADE_STEP;
        set_brightness(ramp_up);
        if (ramp_up >= target) begin
          ramp_up = 8'd0;
          is_on   = want_on;
        end
      end else begin
        // a fresh fade-out starts from the present level
        if (ramp_down == 8'd0) begin
          ramp_down = level;
          target    = (level < LEVEL_MAX) ? level : LEVEL_MAX;
        end
        ramp_down = ramp_down - 8'd1;
        set_brightness(ramp_down);
        if (ramp_down == 8'd0) begin
          lamp_a = 1'b0;
          lamp_b = 1'b0;
          set_brightness(LEVEL_MAX);
          is_on = want_on;
        end
      end
    endfunction

    function void note_word(logic [2:0] op, logic [7:0] lvl, logic en);
      case (op)
        OP_PWM_TICK:  pwm_step();
        OP_FADE_TICK: fade_step();
        OP_SET_LEVEL: set_brightness(lvl);
        OP_STEP: begin
          if (level > STEP_FLOOR) set_brightness(level - STEP_DOWN);
          else set_brightness(LEVEL_MAX);
        end
        OP_ENABLE: begin
          want_on = en;
          if (en) begin
            lamp_a = 1'b0;
            lamp_b = 1'b0;
            set_brightness(8'd0);
          end
        end
        default: ;
      endcase
      status_queue.push_back({6'd0, want_on != is_on, level[6:0], lamp_b, lamp_a});
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        if (errors < 10)
          $display("mismatch on %s (word %0d): expected %0d, got %0d",
                   field, checked, want, got);
        errors++;
      end
    endfunction

    function void check_word(logic [15:0] got);
      logic [15:0] want;
      if (status_queue.size() == 0) begin
        if (errors < 10) $display("status word %h with nothing pending", got);
        errors++;
        return;
      end
      want = status_queue.pop_front();
      compare_field("light1_on", int'(want[0]), int'(got[0]));
      compare_field("light2_on", int'(want[1]), int'(got[1]));
      compare_field("current_level", int'(want[8:2]), int'(got[8:2]));
      compare_field("transitioning", int'(want[9]), int'(got[9]));
      compare_field("pad bits", int'(want[15:10]), int'(got[15:10]));
      checked++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = 16'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  dimmer_scoreboard sb = new();
  int words_sent = 0;

  pwm_led_dimmer_with_fade_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_word(input logic [2:0] op, input logic [7:0] lvl, input logic en);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, en, lvl, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_word(op, lvl, en);
    words_sent++;
    // no gaps through the quiet stretch
    if (words_sent < 850 || words_sent >= 1050) begin
      while ($urandom_range(99) < 11) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic send_any();
    int r;
    logic [2:0] op;
    r = $urandom_range(99);
    if (r < 35) op = OP_PWM_TICK;
    else if (r < 65) op = OP_FADE_TICK;
    else if (r < 75) op = OP_SET_LEVEL;
    else if (r < 83) op = OP_STEP;
    else if (r < 93) op = OP_ENABLE;
    else if (r < 95) op = OP_SPARE_5;
    else if (r < 97) op = OP_SPARE_6;
    else op = OP_SPARE_7;
    send_word(op, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // enable or disable, then a run of fade and pwm ticks with some noise
  task automatic fade_run(input logic turn_on, input int ticks, input int noise_pct);
    int r;
    send_word(OP_ENABLE, 8'($urandom_range(255)), turn_on);
    repeat (ticks) begin
      r = $urandom_range(99);
      if (r < noise_pct) send_any();
      else if (r < 60)
        send_word(OP_FADE_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
      else send_word(OP_PWM_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  // output side: random stalls, one long hold-off, one stall-free stretch
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
      if (!held && sb.checked >= 400) begin
        held = 1'b1;
        hold_left = 250;
      end
      if (rst || hold_left > 0) begin
        if (hold_left > 0) hold_left--;
        m_axis_tready <= 1'b0;
      end else if (sb.checked >= 850 && sb.checked < 1050) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 11);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: idle fade, level extremes, step wrap, spare codes, short fade-in
    send_word(OP_FADE_TICK, 8'h00, 1'b0);
    send_word(OP_PWM_TICK, 8'hff, 1'b1);
    send_word(OP_SET_LEVEL, 8'd0, 1'b0);
    send_word(OP_SET_LEVEL, 8'd255, 1'b0);
    send_word(OP_SET_LEVEL, 8'd4, 1'b0);
    send_word(OP_SET_LEVEL, 8'd5, 1'b0);
    send_word(OP_SET_LEVEL, 8'd101, 1'b0);
    send_word(OP_SET_LEVEL, 8'd12, 1'b0);
    send_word(OP_STEP, 8'd0, 1'b0);
    send_word(OP_SET_LEVEL, 8'd10, 1'b0);
    send_word(OP_STEP, 8'd0, 1'b0);
    send_word(OP_SET_LEVEL, 8'd70, 1'b0);
    send_word(OP_STEP, 8'd0, 1'b0);
    send_word(OP_SPARE_5, 8'hff, 1'b1);
    send_word(OP_SPARE_6, 8'h55, 1'b0);
    send_word(OP_SPARE_7, 8'haa, 1'b1);
    send_word(OP_ENABLE, 8'h00, 1'b1);
    send_word(OP_FADE_TICK, 8'h00, 1'b0);
    send_word(OP_FADE_TICK, 8'h00, 1'b0);
    send_word(OP_ENABLE, 8'h00, 1'b0);
    send_word(OP_FADE_TICK, 8'h00, 1'b0);

    // finish a fade-in, then fade out from level zero all the way through the wrap
    fade_run(1'b1, 130, 0);
    send_word(OP_SET_LEVEL, 8'd0, 1'b0);
    send_word(OP_ENABLE, 8'd0, 1'b0);
    repeat (260)
      send_word(OP_FADE_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));

    while (words_sent < NUM_WORDS) begin
      case ($urandom_range(5))
        0, 1: fade_run(1'b1, $urandom_range(60, 130), 10);
        2, 3: begin
          if ($urandom_range(3) == 0)
            send_word(OP_SET_LEVEL, 8'd0, 1'($urandom_range(1)));
          else
            send_word(OP_SET_LEVEL, 8'($urandom_range(255)), 1'($urandom_range(1)));
          fade_run(1'b0, $urandom_range(60, 150), 10);
        end
        4: repeat (30) send_any();
        default: begin
          repeat ($urandom_range(50, 150)) begin
            if ($urandom_range(9) == 0) send_any();
            else send_word(OP_PWM_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
          end
        end
      endcase
    end
    s_axis_tvalid <= 1'b0;

    while (sb.status_queue.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.status_queue.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
